### src/rfp_pkg.sv
// ----------------------------------------------------------------------------
// Remote frame parser package
// Shared types and constants for the remote control frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SYNC     = 3'd1,
        ST_VERSION  = 3'd2,
        ST_TYPE     = 3'd3,
        ST_PAD      = 3'd4,
        ST_MARK     = 3'd5,
        ST_PARAM    = 3'd6,
        ST_CHECKSUM = 3'd7
    } state_t;

    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [7:0] VERSION_BYTE = 8'h01;
    localparam logic [7:0] PAD_BYTE     = 8'h00;
    localparam logic [7:0] MARK_BYTE    = 8'h01;
    localparam logic [7:0] CSUM_BIAS    = 8'd2;

    localparam logic [3:0] ACT_NONE       = 4'd0;
    localparam logic [3:0] ACT_WIFI_LONG  = 4'd1;
    localparam logic [3:0] ACT_WIFI_SHORT = 4'd2;
    localparam logic [3:0] ACT_FAN_OFF    = 4'd3;
    localparam logic [3:0] ACT_FAN_LOW    = 4'd4;
    localparam logic [3:0] ACT_FAN_MED    = 4'd5;
    localparam logic [3:0] ACT_FAN_HIGH   = 4'd6;
    localparam logic [3:0] ACT_LIGHT      = 4'd7;
    localparam logic [3:0] ACT_EXTRA      = 4'd8;

    localparam logic [7:0] TYPE_WIFI  = 8'd1;
    localparam logic [7:0] TYPE_FAN   = 8'd4;
    localparam logic [7:0] TYPE_EXTRA = 8'd6;

    typedef struct packed {
        state_t     state;
        logic [7:0] cmd_type;
        logic [7:0] cmd_param;
        logic [3:0] action;
        logic       checksum_error;
        logic       unknown_command;
    } step_t;

endpackage

### src/remote_frame_parser.sv
// ----------------------------------------------------------------------------
// Remote frame parser
// Recognizes the eight-byte remote control frame and reports its action.
// ----------------------------------------------------------------------------
// The parser takes one received byte per transaction and returns exactly one
// result transaction for each, in order. It accepts a byte in every cycle that
// rx_stall is low; a byte passes through an input register, and the frame
// state update and command decode sit between that register and the result
// register. A stall on the result side backs up through both registers to
// rx_stall in the same cycle.
module remote_frame_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [3:0] action,
    output logic       checksum_error,
    output logic       unknown_command
);

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    rfp_pkg::state_t state_reg;
    logic [7:0]      cmd_type_reg;
    logic [7:0]      cmd_param_reg;
    logic            res_valid_reg;
    logic [3:0]      action_reg;
    logic            checksum_error_reg;
    logic            unknown_command_reg;
    logic            res_ready;
    logic            in_ready;
    logic            advance;
    rfp_pkg::step_t  step;

    assign res_ready = !res_valid_reg || !res_stall;
    assign in_ready  = !in_valid_reg || res_ready;
    assign advance   = in_valid_reg && res_ready;
    assign rx_stall  = !in_ready;

    rfp_step u_step (
        .state     (state_reg),
        .cmd_type  (cmd_type_reg),
        .cmd_param (cmd_param_reg),
        .rx_byte   (in_byte_reg),
        .step      (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= rfp_pkg::ST_IDLE;
            cmd_type_reg  <= 8'd0;
            cmd_param_reg <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= rx_valid;
            end
            if (res_ready)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (advance)
            begin
                state_reg     <= step.state;
                cmd_type_reg  <= step.cmd_type;
                cmd_param_reg <= step.cmd_param;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && rx_valid)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance)
        begin
            action_reg          <= step.action;
            checksum_error_reg  <= step.checksum_error;
            unknown_command_reg <= step.unknown_command;
        end
    end

    assign res_valid       = res_valid_reg;
    assign action          = action_reg;
    assign checksum_error  = checksum_error_reg;
    assign unknown_command = unknown_command_reg;

`ifndef ASSERT_OFF
    a_start_resyncs: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte_reg == rfp_pkg::START_BYTE) |=> state_reg == rfp_pkg::ST_SYNC)
        else $error("start byte did not restart the frame");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(checksum_error_reg && unknown_command_reg))
        else $error("checksum error and unknown command both set");

    a_action_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && action_reg != rfp_pkg::ACT_NONE)
            |-> (!checksum_error_reg && !unknown_command_reg))
        else $error("action reported together with an error flag");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("transaction lost between input and result register");

    a_result_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg != rfp_pkg::ST_CHECKSUM)
            |=> (action_reg == rfp_pkg::ACT_NONE && !checksum_error_reg
                 && !unknown_command_reg))
        else $error("result flagged outside the checksum byte");
`endif

endmodule

### src/rfp_step.sv
// ----------------------------------------------------------------------------
// Remote frame parser step
// Computes the next frame state and the result for one received byte.
// ----------------------------------------------------------------------------
module rfp_step (
    input  rfp_pkg::state_t state,
    input  logic [7:0]      cmd_type,
    input  logic [7:0]      cmd_param,
    input  logic [7:0]      rx_byte,
    output rfp_pkg::step_t  step
);

    function automatic logic [3:0] decode_pair(input logic [7:0] t, input logic [7:0] p);
        logic [3:0] act;
        begin
            act = rfp_pkg::ACT_NONE;
            case (t)
                rfp_pkg::TYPE_WIFI:
                begin
                    if (p == 8'd1)
                    begin
                        act = rfp_pkg::ACT_WIFI_LONG;
                    end
                    else if (p == 8'd2)
                    begin
                        act = rfp_pkg::ACT_WIFI_SHORT;
                    end
                end
                rfp_pkg::TYPE_FAN:
                begin
                    if (p <= 8'd4)
                    begin
                        act = rfp_pkg::ACT_FAN_OFF + p[3:0];
                    end
                end
                rfp_pkg::TYPE_EXTRA:
                begin
                    if (p == 8'd1)
                    begin
                        act = rfp_pkg::ACT_EXTRA;
                    end
                end
                default:
                begin
                    act = rfp_pkg::ACT_NONE;
                end
            endcase
            return act;
        end
    endfunction

    logic [7:0] sum;
    logic [3:0] decoded;

    assign sum     = rfp_pkg::CSUM_BIAS + cmd_type + cmd_param;
    assign decoded = decode_pair(cmd_type, cmd_param);

    always_comb
    begin
        step.state           = rfp_pkg::ST_IDLE;
        step.cmd_type        = cmd_type;
        step.cmd_param       = cmd_param;
        step.action          = rfp_pkg::ACT_NONE;
        step.checksum_error  = 1'b0;
        step.unknown_command = 1'b0;
        if (rx_byte == rfp_pkg::START_BYTE)
        begin
            step.state = rfp_pkg::ST_SYNC;
        end
        else
        begin
            case (state)
                rfp_pkg::ST_SYNC:
                begin
                    if (rx_byte == rfp_pkg::SYNC_BYTE)
                    begin
                        step.state = rfp_pkg::ST_VERSION;
                    end
                end
                rfp_pkg::ST_VERSION:
                begin
                    if (rx_byte == rfp_pkg::VERSION_BYTE)
                    begin
                        step.state = rfp_pkg::ST_TYPE;
                    end
                end
                rfp_pkg::ST_TYPE:
                begin
                    step.cmd_type = rx_byte;
                    step.state    = rfp_pkg::ST_PAD;
                end
                rfp_pkg::ST_PAD:
                begin
                    if (rx_byte == rfp_pkg::PAD_BYTE)
                    begin
                        step.state = rfp_pkg::ST_MARK;
                    end
                end
                rfp_pkg::ST_MARK:
                begin
                    if (rx_byte == rfp_pkg::MARK_BYTE)
                    begin
                        step.state = rfp_pkg::ST_PARAM;
                    end
                end
                rfp_pkg::ST_PARAM:
                begin
                    step.cmd_param = rx_byte;
                    step.state     = rfp_pkg::ST_CHECKSUM;
                end
                rfp_pkg::ST_CHECKSUM:
                begin
                    if (sum != rx_byte)
                    begin
                        step.checksum_error = 1'b1;
                    end
                    else
                    begin
                        step.action          = decoded;
                        step.unknown_command = (decoded == rfp_pkg::ACT_NONE);
                    end
                end
                default:
                begin
                    step.state = rfp_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Remote frame parser testbench
// Sends framed and noisy byte streams through the parser under random idle
// and stall bursts, and checks every result against a local frame predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_ITEMS     = 750;
    localparam int QUIET_TAIL  = 100;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [3:0] action;
        logic       checksum_error;
        logic       unknown_command;
    } report_t;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       rx_valid = 1'b0;
    logic       rx_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [3:0] action;
    logic       checksum_error;
    logic       unknown_command;

    logic [7:0] byte_q[$];
    report_t    report_q[$];

    rfp_pkg::state_t frame_pos = rfp_pkg::ST_IDLE;
    logic [7:0]      cmd_type = 8'h00;
    logic [7:0]      cmd_param = 8'h00;

    int send_gap = 0;
    int stall_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int reports_seen = 0;
    int good_frames = 0;
    int csum_errors = 0;
    int unknown_cmds = 0;

    remote_frame_parser dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .action          (action),
        .checksum_error  (checksum_error),
        .unknown_command (unknown_command)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // The frame state advances once for every byte transaction the parser accepts.
    function automatic report_t parse_byte(input logic [7:0] b);
        report_t    r;
        logic [7:0] sum;
        r = '{rfp_pkg::ACT_NONE, 1'b0, 1'b0};
        if (b == rfp_pkg::START_BYTE)
            frame_pos = rfp_pkg::ST_SYNC;
        else
        begin
            case (frame_pos)
                rfp_pkg::ST_SYNC:
                begin
                    frame_pos = (b == rfp_pkg::SYNC_BYTE) ? rfp_pkg::ST_VERSION
                                                          : rfp_pkg::ST_IDLE;
                end
                rfp_pkg::ST_VERSION:
                begin
                    frame_pos = (b == rfp_pkg::VERSION_BYTE) ? rfp_pkg::ST_TYPE
                                                             : rfp_pkg::ST_IDLE;
                end
                rfp_pkg::ST_TYPE:
                begin
                    cmd_type = b;
                    frame_pos = rfp_pkg::ST_PAD;
                end
                rfp_pkg::ST_PAD:
                begin
                    frame_pos = (b == rfp_pkg::PAD_BYTE) ? rfp_pkg::ST_MARK
                                                         : rfp_pkg::ST_IDLE;
                end
                rfp_pkg::ST_MARK:
                begin
                    frame_pos = (b == rfp_pkg::MARK_BYTE) ? rfp_pkg::ST_PARAM
                                                          : rfp_pkg::ST_IDLE;
                end
                rfp_pkg::ST_PARAM:
                begin
                    cmd_param = b;
                    frame_pos = rfp_pkg::ST_CHECKSUM;
                end
                rfp_pkg::ST_CHECKSUM:
                begin
                    sum = rfp_pkg::CSUM_BIAS + cmd_type + cmd_param;
                    if (sum != b)
                    begin
                        r.checksum_error = 1'b1;
                        csum_errors++;
                    end
                    else
                    begin
                        case (cmd_type)
                            rfp_pkg::TYPE_WIFI:
                                if (cmd_param == 8'd1)
                                    r.action = rfp_pkg::ACT_WIFI_LONG;
                                else if (cmd_param == 8'd2)
                                    r.action = rfp_pkg::ACT_WIFI_SHORT;
                            rfp_pkg::TYPE_FAN:
                                if (cmd_param <= 8'd4)
                                    r.action = rfp_pkg::ACT_FAN_OFF + cmd_param[3:0];
                            rfp_pkg::TYPE_EXTRA:
                                if (cmd_param == 8'd1)
                                    r.action = rfp_pkg::ACT_EXTRA;
                            default: ;
                        endcase
                        if (r.action == rfp_pkg::ACT_NONE)
                        begin
                            r.unknown_command = 1'b1;
                            unknown_cmds++;
                        end
                        else
                            good_frames++;
                    end
                    frame_pos = rfp_pkg::ST_IDLE;
                end
                default:     frame_pos = rfp_pkg::ST_IDLE;
            endcase
        end
        return r;
    endfunction

    task automatic push_frame(input logic [7:0] t, input logic [7:0] p, input logic [7:0] c);
        byte_q.push_back(rfp_pkg::START_BYTE);
        byte_q.push_back(rfp_pkg::SYNC_BYTE);
        byte_q.push_back(rfp_pkg::VERSION_BYTE);
        byte_q.push_back(t);
        byte_q.push_back(rfp_pkg::PAD_BYTE);
        byte_q.push_back(rfp_pkg::MARK_BYTE);
        byte_q.push_back(p);
        byte_q.push_back(c);
    endtask

    task automatic note_mismatch(input string what, input report_t exp_r, input report_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display({"%0t: %s: expected action %0d cerr %0b unk %0b, ",
                      "got action %0d cerr %0b unk %0b"},
                     $time, what, exp_r.action, exp_r.checksum_error, exp_r.unknown_command,
                     got_r.action, got_r.checksum_error, got_r.unknown_command);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_valid <= 1'b0;
            rx_byte <= 8'h00;
        end
        else
        begin
            if (rx_valid && !rx_stall)
                report_q.push_back(parse_byte(rx_byte));
            if (!rx_valid || !rx_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    rx_valid <= 1'b0;
                end
                else if (byte_q.size() > 0)
                begin
                    rx_valid <= 1'b1;
                    rx_byte <= byte_q.pop_front();
                    if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 15);
                end
                else
                    rx_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        report_t got_r;
        if (!rst_n)
            res_stall <= 1'b0;
        else
        begin
            if (res_valid && !res_stall)
            begin
                got_r = '{action, checksum_error, unknown_command};
                reports_seen++;
                if (report_q.size() == 0)
                    note_mismatch("unexpected result transaction", '0, got_r);
                else if (report_q[0] != got_r)
                    note_mismatch("result mismatch", report_q.pop_front(), got_r);
                else
                    void'(report_q.pop_front());
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                if (byte_q.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run timed out after %0d cycles with %0d results outstanding.",
                     cycles, report_q.size());
            $display("** remote_frame_parser: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int         sel;
        int         n;
        logic [7:0] t;
        logic [7:0] p;
        logic [7:0] c;

        // A good frame, an AA in the type slot that restarts into an unknown pair at
        // the byte extremes, idle noise and a wrong version byte.
        push_frame(rfp_pkg::TYPE_WIFI, 8'd1, 8'd4);
        byte_q.push_back(rfp_pkg::START_BYTE);
        byte_q.push_back(rfp_pkg::SYNC_BYTE);
        byte_q.push_back(rfp_pkg::VERSION_BYTE);
        push_frame(8'hFF, 8'hFF, 8'h00);
        byte_q.push_back(8'h00);
        byte_q.push_back(rfp_pkg::START_BYTE);
        byte_q.push_back(rfp_pkg::SYNC_BYTE);
        byte_q.push_back(8'h00);

        while (byte_q.size() < N_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 8)
            begin
                n = $urandom_range(0, 11);
                case (n)
                    0:
                    begin
                        t = rfp_pkg::TYPE_WIFI;
                        p = 8'd1;
                    end
                    1:
                    begin
                        t = rfp_pkg::TYPE_WIFI;
                        p = 8'd2;
                    end
                    2, 3, 4, 5, 6:
                    begin
                        t = rfp_pkg::TYPE_FAN;
                        p = 8'(n - 2);
                    end
                    7:
                    begin
                        t = rfp_pkg::TYPE_EXTRA;
                        p = 8'd1;
                    end
                    default:
                    begin
                        t = 8'($urandom_range(0, 255));
                        p = 8'($urandom_range(0, 255));
                    end
                endcase
                c = rfp_pkg::CSUM_BIAS + t + p;
                if ($urandom_range(0, 6) == 0)
                    c = 8'($urandom_range(0, 255));
                push_frame(t, p, c);
                if (sel == 7)
                begin
                    case ($urandom_range(0, 3))
                        0:       n = 1;
                        1:       n = 2;
                        2:       n = 4;
                        default: n = 5;
                    endcase
                    byte_q[byte_q.size() - 8 + n] = 8'($urandom_range(0, 255));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    byte_q.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || rx_valid || report_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d result transactions: %0d decoded actions, %0d checksum errors,",
                 reports_seen, good_frames, csum_errors);
        $display("%0d unknown commands, %0d mismatches.", unknown_cmds, mismatches);
        if (mismatches == 0 && report_q.size() == 0)
            $display("** remote_frame_parser: PASSED **");
        else
            $display("** remote_frame_parser: FAILED **");
        $finish;
    end
endmodule

### remote_frame_parser.f
src/rfp_pkg.sv
src/rfp_step.sv
src/remote_frame_parser.sv
test/testbench.sv
